/* design/p1305_pkg.sv */
// Shared types, constants and control encodings for the Poly1305 MAC core.
package p1305_pkg;

	localparam int NLIMB     = 5;
	localparam int LIMB_W    = 26;
	localparam int ACC_W     = 27;
	localparam int H_W       = 28;
	localparam int S_W       = 29;
	localparam int PROD_W    = H_W + S_W;
	localparam int D_W       = 61;
	localparam int CARRY_W   = D_W - LIMB_W;
	localparam int ROW_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int CNT_W     = 5;
	localparam int HALF_W    = 64;
	localparam int BLK_W     = 2 * HALF_W;
	localparam int WIDE_W    = NLIMB * LIMB_W;

	localparam logic [CNT_W-1:0] BLK_BYTES = CNT_W'(16);

	typedef logic [NLIMB-1:0][LIMB_W-1:0]  limbs_t;
	typedef logic [NLIMB-1:0][ACC_W-1:0]   acc_limbs_t;
	typedef logic [NLIMB-1:0][H_W-1:0]     h_limbs_t;
	typedef logic [NLIMB-1:0][S_W-1:0]     s_limbs_t;
	typedef logic [NLIMB-1:0][PROD_W-1:0]  prods_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_R_LOW  = 3'd0,
		CFG_KEY_R_HIGH = 3'd1,
		CFG_PAD_LOW    = 3'd2,
		CFG_PAD_HIGH   = 3'd3,
		CFG_EXP_LOW    = 3'd4,
		CFG_EXP_HIGH   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic             mul_en;
		logic [ROW_W-1:0] mul_row;
		logic             sum_en;
		logic [ROW_W-1:0] sum_row;
		logic             fold_en;
		logic             fin1_en;
		logic             fin2_en;
		logic             fin3_en;
	} ctrl_t;

endpackage

/* design/p1305_seq.sv */
// Sequencer for the Poly1305 core: row loop, fold and finalize steps.
module p1305_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            start_absorb,
	input  logic            start_fin,
	input  logic            out_free,
	output logic            busy,
	output p1305_pkg::ctrl_t ctrl
);
	import p1305_pkg::*;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  cnt_q;
	logic              fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL)
				cnt_q <= cnt_q + ROW_W'(1);
			else
				cnt_q <= '0;
			if (start)
				fin_q <= start_fin;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = start_absorb ? ST_MUL : ST_FIN1;
			end
			ST_MUL: begin
				if (cnt_q == ROW_W'(NLIMB))
					state_d = ST_FOLD;
			end
			ST_FOLD: state_d = fin_q ? ST_FIN1 : ST_IDLE;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_FIN3;
			ST_FIN3: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl         = '0;
		ctrl.mul_row = cnt_q;
		ctrl.sum_row = cnt_q - ROW_W'(1);
		case (state_q)
			ST_MUL: begin
				ctrl.mul_en = (cnt_q < ROW_W'(NLIMB));
				ctrl.sum_en = (cnt_q != '0);
			end
			ST_FOLD: ctrl.fold_en = 1'b1;
			ST_FIN1: ctrl.fin1_en = 1'b1;
			ST_FIN2: ctrl.fin2_en = 1'b1;
			ST_FIN3: ctrl.fin3_en = out_free;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* design/p1305_mulred.sv */
// Shared five-multiplier row bank with carry chain and partial reduction.
module p1305_mulred (
	input  logic                  clk,
	input  p1305_pkg::ctrl_t      ctrl,
	input  p1305_pkg::h_limbs_t   h,
	input  p1305_pkg::limbs_t     r,
	input  p1305_pkg::s_limbs_t   s,
	output p1305_pkg::acc_limbs_t acc_new
);
	import p1305_pkg::*;

	localparam int FOLD_W = CARRY_W + 4;

	s_limbs_t            coef;
	prods_t              prod_s1;
	limbs_t              nh_q;
	logic [CARRY_W-1:0]  carry_q;
	logic [CARRY_W-1:0]  carry_in;
	logic [D_W-1:0]      dsum;
	logic [FOLD_W-1:0]   t0;

	// row j: h[i] times r[j-i], or 5*r[j-i+5] where the index wraps
	always_comb begin
		for (int i = 0; i < NLIMB; i++) begin
			if (ctrl.mul_row >= ROW_W'(i))
				coef[i] = S_W'(r[ctrl.mul_row - ROW_W'(i)]);
			else
				coef[i] = s[ctrl.mul_row + ROW_W'(NLIMB - i)];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			for (int i = 0; i < NLIMB; i++)
				prod_s1[i] <= PROD_W'(h[i]) * PROD_W'(coef[i]);
		end
	end

	always_comb begin
		carry_in = (ctrl.sum_row == '0) ? '0 : carry_q;
		dsum     = D_W'(carry_in);
		for (int i = 0; i < NLIMB; i++)
			dsum = dsum + D_W'(prod_s1[i]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			nh_q[ctrl.sum_row] <= dsum[LIMB_W-1:0];
			carry_q            <= dsum[D_W-1:LIMB_W];
		end
	end

	// top carry folds back times 5 since 2^130 = 5 mod p
	always_comb begin
		t0 = FOLD_W'(nh_q[0]) + (FOLD_W'(carry_q) << 2) + FOLD_W'(carry_q);
		acc_new[0] = ACC_W'(t0[LIMB_W-1:0]);
		acc_new[1] = ACC_W'(nh_q[1]) + ACC_W'(t0[FOLD_W-1:LIMB_W]);
		for (int i = 2; i < NLIMB; i++)
			acc_new[i] = ACC_W'(nh_q[i]);
	end

endmodule

/* design/p1305_final.sv */
// Final reduction mod 2^130-5, pad addition and tag compare.
module p1305_final (
	input  logic                        clk,
	input  p1305_pkg::ctrl_t            ctrl,
	input  p1305_pkg::acc_limbs_t       acc,
	input  logic [p1305_pkg::BLK_W-1:0] pad,
	input  logic [p1305_pkg::BLK_W-1:0] expect_tag,
	output logic [p1305_pkg::BLK_W-1:0] tag,
	output logic                        tag_eq
);
	import p1305_pkg::*;

	acc_limbs_t           hr, hr_q, f;
	limbs_t               g;
	logic [H_W-1:0]       t, t0, u4, tg;
	logic [1:0]           c;
	logic [2:0]           gc;
	logic                 sel;
	logic [HALF_W-1:0]    lo, hi;
	logic [BLK_W-1:0]     packed_q;
	logic [HALF_W:0]      sum_lo;
	logic [HALF_W-1:0]    sum_hi;
	logic [BLK_W-1:0]     tag_d;
	logic [BLK_W-1:0]     tag_q;
	logic                 match_q;

	// step 1: full carry pass
	always_comb begin
		c     = '0;
		hr[0] = '0;
		for (int i = 1; i < NLIMB; i++) begin
			t     = H_W'(acc[i]) + H_W'(c);
			hr[i] = ACC_W'(t[LIMB_W-1:0]);
			c     = t[H_W-1:LIMB_W];
		end
		t0    = H_W'(acc[0]) + (H_W'(c) << 2) + H_W'(c);
		hr[0] = ACC_W'(t0[LIMB_W-1:0]);
		hr[1] = hr[1] + ACC_W'(t0[H_W-1:LIMB_W]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin1_en)
			hr_q <= hr;
	end

	// step 2: take h - p when h >= p, then pack to 128 bits
	always_comb begin
		gc = 3'd5;
		for (int i = 0; i < NLIMB - 1; i++) begin
			tg   = H_W'(hr_q[i]) + H_W'(gc);
			g[i] = tg[LIMB_W-1:0];
			gc   = 3'(tg[H_W-1:LIMB_W]);
		end
		u4       = H_W'(hr_q[NLIMB-1]) + H_W'(gc);
		sel      = |u4[H_W-1:LIMB_W];
		g[NLIMB-1] = u4[LIMB_W-1:0];
		for (int i = 0; i < NLIMB; i++)
			f[i] = sel ? ACC_W'(g[i]) : hr_q[i];
		lo = HALF_W'(f[0]) | (HALF_W'(f[1]) << 26) | (HALF_W'(f[2]) << 52);
		hi = HALF_W'(f[2] >> 12) | (HALF_W'(f[3]) << 14) | (HALF_W'(f[4]) << 40);
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin2_en)
			packed_q <= {hi, lo};
	end

	// step 3: add pad mod 2^128 and compare
	always_comb begin
		sum_lo = (HALF_W+1)'(packed_q[HALF_W-1:0]) + (HALF_W+1)'(pad[HALF_W-1:0]);
		sum_hi = packed_q[BLK_W-1:HALF_W] + pad[BLK_W-1:HALF_W] + HALF_W'(sum_lo[HALF_W]);
		tag_d  = {sum_hi, sum_lo[HALF_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin3_en) begin
			tag_q   <= tag_d;
			match_q <= (tag_d == expect_tag);
		end
	end

	assign tag    = tag_q;
	assign tag_eq = match_q;

endmodule

/* design/poly1305_mac.sv */
// Top level of the Poly1305 MAC core: config registers, block intake, output beat.
//
// One 16-byte block per input beat; in_stall stays high while the core works on it.
// A block that only absorbs occupies the core for the beat, six steps of the row
// loop through the shared bank of five 28x29 multipliers (one accumulator row per
// cycle, carry chained from row to row) and the fold step. A finalizing item then
// runs the carry pass, conditional subtract of p, and pad add and compare; the last
// waits while out_stall still holds a previous tag beat. A zero-byte item skips the
// row loop and only finalizes. Key, pad and expected tag come through the cfg port;
// the user must write them only while the core is idle, which is not enforced.
module poly1305_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p1305_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [p1305_pkg::HALF_W-1:0]    block_low,
	input  logic [p1305_pkg::HALF_W-1:0]    block_high,
	input  logic [p1305_pkg::CNT_W-1:0]     byte_count,
	input  logic                            last_block,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [p1305_pkg::HALF_W-1:0]    tag_low,
	output logic [p1305_pkg::HALF_W-1:0]    tag_high,
	output logic                            tag_matches
);
	import p1305_pkg::*;

	localparam limbs_t CLAMP = {26'h00fffff, 26'h3f03fff, 26'h3ffc0ff,
		26'h3ffff03, 26'h3ffffff};

	logic [CFG_W-1:0]  key_lo_q, key_hi_q, pad_lo_q, pad_hi_q, exp_lo_q, exp_hi_q;
	acc_limbs_t        acc_q, acc_new;
	h_limbs_t          h_q, h_d;
	limbs_t            r_q, r_d;
	s_limbs_t          s_q, s_d;
	logic              accept, busy, out_valid_q, out_free;
	logic [CNT_W-1:0]  n_eff;
	logic              full, absorb, fin;
	logic [6:0]        bitpos;
	logic [BLK_W-1:0]  data, one_hot, short_msg;
	logic [WIDE_W-1:0] msg_x, key_x;
	logic [BLK_W-1:0]  tag;
	logic              tag_eq;
	ctrl_t             ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			pad_lo_q <= '0;
			pad_hi_q <= '0;
			exp_lo_q <= '0;
			exp_hi_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_R_LOW:  key_lo_q <= cfg_data;
				CFG_KEY_R_HIGH: key_hi_q <= cfg_data;
				CFG_PAD_LOW:    pad_lo_q <= cfg_data;
				CFG_PAD_HIGH:   pad_hi_q <= cfg_data;
				CFG_EXP_LOW:    exp_lo_q <= cfg_data;
				CFG_EXP_HIGH:   exp_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept = in_valid && !in_stall;

	// short block: mask unused bytes and append a 1 byte; full block: add 2^128
	always_comb begin
		n_eff     = (byte_count > BLK_BYTES) ? BLK_BYTES : byte_count;
		full      = (n_eff == BLK_BYTES);
		absorb    = (n_eff != '0);
		fin       = !full || last_block;
		bitpos    = {n_eff[3:0], 3'b000};
		data      = {block_high, block_low};
		one_hot   = BLK_W'(1) << bitpos;
		short_msg = (data & (one_hot - BLK_W'(1))) | one_hot;
		msg_x     = full ? WIDE_W'({1'b1, data}) : WIDE_W'(short_msg);
		key_x     = WIDE_W'({key_hi_q, key_lo_q});
		for (int i = 0; i < NLIMB; i++) begin
			h_d[i] = H_W'(acc_q[i]) + H_W'(msg_x[i*LIMB_W +: LIMB_W]);
			r_d[i] = key_x[i*LIMB_W +: LIMB_W] & CLAMP[i];
			s_d[i] = (S_W'(r_d[i]) << 2) + S_W'(r_d[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q <= h_d;
			r_q <= r_d;
			s_q <= s_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (ctrl.fold_en)
			acc_q <= acc_new;
		else if (ctrl.fin3_en)
			acc_q <= '0;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.fin3_en)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	p1305_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.start_absorb (absorb),
		.start_fin    (fin),
		.out_free     (out_free),
		.busy         (busy),
		.ctrl         (ctrl)
	);

	p1305_mulred u_mulred (
		.clk     (clk),
		.ctrl    (ctrl),
		.h       (h_q),
		.r       (r_q),
		.s       (s_q),
		.acc_new (acc_new)
	);

	p1305_final u_final (
		.clk        (clk),
		.ctrl       (ctrl),
		.acc        (acc_q),
		.pad        ({pad_hi_q, pad_lo_q}),
		.expect_tag ({exp_hi_q, exp_lo_q}),
		.tag        (tag),
		.tag_eq     (tag_eq)
	);

	assign in_stall    = busy;
	assign out_valid   = out_valid_q;
	assign tag_low     = tag[HALF_W-1:0];
	assign tag_high    = tag[BLK_W-1:HALF_W];
	assign tag_matches = tag_eq;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.fin3_en))
		else $error("output beat raised without a finalize step");

	a_fold_after_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fold_en |-> $past(ctrl.sum_en && ctrl.sum_row == ROW_W'(NLIMB - 1)))
		else $error("fold without the last accumulator row");

	a_empty_finalizes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && n_eff == '0) |=> ctrl.fin1_en)
		else $error("zero-byte beat did not go straight to finalize");

endmodule
